### sv/lcs_pkg.sv
// shared types, codes and helper functions for the light channel sequencer
package lcs_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // program command codes
  localparam logic [3:0] CMD_FRAME_START = 4'd0;
  localparam logic [3:0] CMD_FRAME_END   = 4'd1;
  localparam logic [3:0] CMD_SELECT      = 4'd2;
  localparam logic [3:0] CMD_SET         = 4'd3;
  localparam logic [3:0] CMD_SET_TIME    = 4'd4;
  localparam logic [3:0] CMD_WAIT        = 4'd5;
  localparam logic [3:0] CMD_JUMP        = 4'd6;
  localparam logic [3:0] CMD_FADE_UP     = 4'd7;
  localparam logic [3:0] CMD_FADE_DOWN   = 4'd8;
  localparam logic [3:0] CMD_LOOP_INIT   = 4'd9;
  localparam logic [3:0] CMD_LOOP_CHECK  = 4'd10;

  // configuration register indexes
  localparam logic [1:0] REG_FADE_CEILING  = 2'd0;
  localparam logic [1:0] REG_FADE_FLOOR    = 2'd1;
  localparam logic [1:0] REG_CHANNEL_LIMIT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic fetch;
    logic exec;
    logic mod_step;
    logic mod_apply;
    logic rd_level;
    logic finish;
  } lcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic exec_stop;
    logic exec_mod;
    logic limit_hit;
    logic mod_last;
    logic out_free;
  } lcs_sts_t;

  function automatic logic [7:0] lcs_clamp(input logic [7:0] v, input logic [7:0] lim);
    lcs_clamp = (v > lim) ? lim : v;
  endfunction

  // multiplier ceil(2^s / d) with s = 16 + clog2(d): exact quotient for any 16 bit value
  function automatic logic [16:0] lcs_recip(input int unsigned d);
    int unsigned     s;
    longint unsigned m;
    s = 16 + $clog2(d);
    m = ((64'd1 << s) + 64'(d) - 64'd1) / 64'(d);
    lcs_recip = m[16:0];
  endfunction

endpackage

### sv/lcs_ctrl.sv
// controller state machine of the light channel sequencer
module lcs_ctrl import lcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  input  lcs_sts_t   sts,
  output lcs_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_EXEC  = 7'b0001000,
    ST_MOD   = 7'b0010000,
    ST_RDLVL = 7'b0100000,
    ST_DONE  = 7'b1000000
  } lcs_state_t;

  lcs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_opcode)
            OP_TICK: state_nxt = ST_FETCH;
            OP_READ: state_nxt = ST_RDLVL;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.exec_stop) state_nxt = ST_DONE;
        else if (sts.exec_mod) state_nxt = ST_MOD;
        else if (sts.limit_hit) state_nxt = ST_DONE;
        else state_nxt = ST_FETCH;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          cmd.mod_apply = 1'b1;
          state_nxt = sts.limit_hit ? ST_DONE : ST_FETCH;
        end
      end
      ST_RDLVL: begin
        cmd.rd_level = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

### sv/lcs_dpath.sv
// datapath of the light channel sequencer: stores, sequencer state, execute and remainder units
module lcs_dpath import lcs_pkg::*; #(
  parameter int PROGRAM_DEPTH      = 256,
  parameter int CHANNEL_COUNT      = 64,
  parameter int MAX_STEPS_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lcs_cmd_t    cmd,
  output lcs_sts_t    sts,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_address,
  input  logic [3:0]  in_command_code,
  input  logic [15:0] in_argument,
  input  logic [5:0]  in_read_channel,
  input  logic [7:0]  fade_ceiling,
  input  logic [7:0]  fade_floor,
  input  logic [7:0]  channel_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_level_out,
  output logic [7:0]  out_step_now,
  output logic        out_step_overflow
);

  localparam int PW  = $clog2(PROGRAM_DEPTH);
  localparam int CW  = $clog2(CHANNEL_COUNT);
  localparam int SCW = $clog2(MAX_STEPS_PER_TICK + 1);
  localparam logic [16:0] RCP_PROG = lcs_recip(PROGRAM_DEPTH);
  localparam logic [16:0] RCP_CHAN = lcs_recip(CHANNEL_COUNT);
  localparam int SH_PROG = 16 + $clog2(PROGRAM_DEPTH);
  localparam int SH_CHAN = 16 + $clog2(CHANNEL_COUNT);

  // stores
  logic [3:0]  prog_cmd_mem [PROGRAM_DEPTH];
  logic [15:0] prog_arg_mem [PROGRAM_DEPTH];
  logic [7:0]  lvl_mem      [CHANNEL_COUNT];
  logic [3:0]  prog_cmd_rd_r;
  logic [15:0] prog_arg_rd_r;
  logic [7:0]  lvl_rd_r;

  // sequencer state
  logic [PW-1:0]  sp_r, sp_nxt;
  logic [CW-1:0]  sel_r, sel_nxt;
  logic [15:0]    wait_r, wait_nxt;
  logic [15:0]    loop_cnt_r, loop_cnt_nxt;
  logic [PW-1:0]  loop_start_r, loop_start_nxt;
  logic [CW-1:0]  clr_r;
  logic [SCW-1:0] step_cnt_r;
  logic           overflow_r;

  // latched request
  logic [1:0] op_r;
  logic [5:0] rch_r;

  // remainder unit
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r;
  logic        mod_ph_r;
  logic        mod_jump_r;
  logic [15:0] mod_div;
  logic [16:0] mod_rcp;
  logic [32:0] mod_prod;
  logic [15:0] mod_quo;

  // output register
  logic       out_valid_r;
  logic [7:0] out_level_r;
  logic [7:0] out_step_r;
  logic       out_ovf_r;

  // execute
  logic          ex_stop, ex_mod, ex_lvl_we;
  logic [7:0]    ex_lvl_wd;
  logic [7:0]    up_diff, dn_diff, up_val, dn_val;
  logic [PW-1:0] sp_inc;
  logic          step_done;

  // address handling
  logic [31:0]   ea_ext, rch_ext, sp_ext;
  logic          ea_ok, rch_ok;
  logic [PW-1:0] ea_idx;
  logic [CW-1:0] rch_idx;
  logic          prog_we;
  logic          lvl_we, lvl_re;
  logic [CW-1:0] lvl_wa, lvl_ra;
  logic [7:0]    lvl_wd;

  assign ea_ext  = {24'd0, in_entry_address};
  assign ea_ok   = (ea_ext < 32'(PROGRAM_DEPTH));
  assign ea_idx  = ea_ext[PW-1:0];
  assign rch_ext = {26'd0, rch_r};
  assign rch_ok  = (rch_ext < 32'(CHANNEL_COUNT));
  assign rch_idx = rch_ext[CW-1:0];
  assign sp_ext  = 32'(sp_r);

  assign prog_we = cmd.accept && (in_opcode == OP_WRITE) && ea_ok;

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_cmd_mem[ea_idx] <= in_command_code;
      prog_arg_mem[ea_idx] <= in_argument;
    end
    if (cmd.fetch) begin
      prog_cmd_rd_r <= prog_cmd_mem[sp_r];
      prog_arg_rd_r <= prog_arg_mem[sp_r];
    end
  end

  // level store: one write port, one registered read port
  assign lvl_we = cmd.clear_wr || (cmd.exec && ex_lvl_we);
  assign lvl_wa = cmd.clear_wr ? clr_r : sel_r;
  assign lvl_wd = cmd.clear_wr ? 8'd0 : ex_lvl_wd;
  assign lvl_re = cmd.fetch || cmd.rd_level;
  assign lvl_ra = cmd.rd_level ? rch_idx : sel_r;

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (lvl_re) lvl_rd_r <= lvl_mem[lvl_ra];
  end

  // fade arithmetic
  assign up_diff = fade_ceiling - lvl_rd_r;
  assign dn_diff = lvl_rd_r - fade_floor;
  always_comb begin
    if (lvl_rd_r < fade_ceiling) begin
      up_val = ({8'd0, up_diff} >= prog_arg_rd_r) ? (lvl_rd_r + prog_arg_rd_r[7:0])
                                                   : fade_ceiling;
    end else begin
      up_val = lvl_rd_r;
    end
    if (lvl_rd_r > fade_floor) begin
      dn_val = ({8'd0, dn_diff} >= prog_arg_rd_r) ? (lvl_rd_r - prog_arg_rd_r[7:0])
                                                   : fade_floor;
    end else begin
      dn_val = lvl_rd_r;
    end
  end

  assign sp_inc = (sp_r == PW'(PROGRAM_DEPTH - 1)) ? '0 : sp_r + PW'(1);

  // remainder by reciprocal multiplication: the quotient is registered, the remainder follows from it in the next cycle
  assign mod_div  = mod_jump_r ? 16'(PROGRAM_DEPTH) : 16'(CHANNEL_COUNT);
  assign mod_rcp  = mod_jump_r ? RCP_PROG : RCP_CHAN;
  assign mod_prod = {17'd0, rem_r} * {16'd0, mod_rcp};
  assign mod_quo  = mod_jump_r ? 16'(mod_prod >> SH_PROG) : 16'(mod_prod >> SH_CHAN);
  assign rem_nxt  = rem_r - quo_r * mod_div;

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_mod) begin
      rem_r      <= prog_arg_rd_r;
      mod_jump_r <= (prog_cmd_rd_r == CMD_JUMP);
      mod_ph_r   <= 1'b0;
    end else if (cmd.mod_step) begin
      quo_r    <= mod_quo;
      mod_ph_r <= 1'b1;
    end
  end

  // one command
  always_comb begin
    ex_stop        = 1'b0;
    ex_mod         = 1'b0;
    ex_lvl_we      = 1'b0;
    ex_lvl_wd      = 8'd0;
    sp_nxt         = sp_inc;
    sel_nxt        = sel_r;
    wait_nxt       = wait_r;
    loop_cnt_nxt   = loop_cnt_r;
    loop_start_nxt = loop_start_r;
    case (prog_cmd_rd_r)
      CMD_FRAME_START: begin
      end
      CMD_FRAME_END: begin
        ex_stop = 1'b1;
      end
      CMD_SELECT: begin
        ex_mod = 1'b1;
        sp_nxt = sp_r;
      end
      CMD_SET: begin
        ex_lvl_we = 1'b1;
        ex_lvl_wd = lcs_clamp(prog_arg_rd_r[7:0], channel_limit);
      end
      CMD_SET_TIME: begin
        wait_nxt = prog_arg_rd_r;
      end
      CMD_WAIT: begin
        if (wait_r != 16'd0) begin
          wait_nxt = wait_r - 16'd1;
          ex_stop  = 1'b1;
          sp_nxt   = sp_r;
        end
      end
      CMD_JUMP: begin
        ex_mod = 1'b1;
        sp_nxt = sp_r;
      end
      CMD_FADE_UP: begin
        ex_lvl_we = 1'b1;
        ex_lvl_wd = lcs_clamp(up_val, channel_limit);
      end
      CMD_FADE_DOWN: begin
        ex_lvl_we = 1'b1;
        ex_lvl_wd = lcs_clamp(dn_val, channel_limit);
      end
      CMD_LOOP_INIT: begin
        loop_cnt_nxt   = prog_arg_rd_r;
        loop_start_nxt = sp_inc;
      end
      CMD_LOOP_CHECK: begin
        if (loop_cnt_r != 16'd0) begin
          loop_cnt_nxt = loop_cnt_r - 16'd1;
          sp_nxt       = loop_start_r;
        end
      end
      default: begin
        sp_nxt  = '0;
        ex_stop = 1'b1;
      end
    endcase
  end

  assign step_done = (cmd.exec && !ex_stop && !ex_mod) || cmd.mod_apply;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r         <= '0;
      sel_r        <= '0;
      wait_r       <= 16'd0;
      loop_cnt_r   <= 16'd0;
      loop_start_r <= '0;
      clr_r        <= '0;
      step_cnt_r   <= '0;
      overflow_r   <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_r <= clr_r + CW'(1);
      if (cmd.exec) begin
        sp_r         <= sp_nxt;
        sel_r        <= sel_nxt;
        wait_r       <= wait_nxt;
        loop_cnt_r   <= loop_cnt_nxt;
        loop_start_r <= loop_start_nxt;
      end else if (cmd.mod_apply) begin
        if (mod_jump_r) sp_r <= rem_nxt[PW-1:0];
        else begin
          sel_r <= rem_nxt[CW-1:0];
          sp_r  <= sp_inc;
        end
      end
      if (cmd.accept) begin
        step_cnt_r <= '0;
        overflow_r <= 1'b0;
      end else if (step_done) begin
        step_cnt_r <= step_cnt_r + SCW'(1);
        if (sts.limit_hit) overflow_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      rch_r <= in_read_channel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_level_r <= ((op_r == OP_READ) && rch_ok) ? lvl_rd_r : 8'd0;
      out_step_r  <= sp_ext[7:0];
      out_ovf_r   <= (op_r == OP_TICK) && overflow_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_out     = out_level_r;
  assign out_step_now      = out_step_r;
  assign out_step_overflow = out_ovf_r;

  assign sts.clear_last = (clr_r == CW'(CHANNEL_COUNT - 1));
  assign sts.exec_stop  = ex_stop;
  assign sts.exec_mod   = ex_mod;
  assign sts.limit_hit  = (step_cnt_r == SCW'(MAX_STEPS_PER_TICK - 1));
  assign sts.mod_last   = mod_ph_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

### sv/light_channel_sequencer.sv
// top level of the light channel sequencer: register port, controller and datapath
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_stall   opcode, entry_address, command_code,
//                                              argument, read_channel
//   out_      result     out_valid / out_stall level_out, step_now, step_overflow
//   cfg       registers  psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// steps: a program write passes accept and result, a level read adds a level store read;
//   a tick fetches and executes each command between accept and result, and select or
//   jump also pass the reciprocal remainder unit, quotient first, then remainder; the
//   fetch/execute loop runs through the program and level stores
// reset: after rst_n the level store is zeroed in one pass over all CHANNEL_COUNT channels,
//   in_stall stays high during it; register writes are taken throughout
// stalls: one request is in flight at a time; a finished result waits in the output
//   register while the next request is accepted
module light_channel_sequencer import lcs_pkg::*; #(
  parameter int PROGRAM_DEPTH      = 256,
  parameter int CHANNEL_COUNT      = 64,
  parameter int MAX_STEPS_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_address,
  input  logic [3:0]  in_command_code,
  input  logic [15:0] in_argument,
  input  logic [5:0]  in_read_channel,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_level_out,
  output logic [7:0]  out_step_now,
  output logic        out_step_overflow,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] fade_ceiling_r;
  logic [7:0] fade_floor_r;
  logic [7:0] channel_limit_r;
  logic       reg_wr;
  lcs_cmd_t   cmd;
  lcs_sts_t   sts;

  // register file, written on the access phase
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_ceiling_r  <= 8'd255;
      fade_floor_r    <= 8'd0;
      channel_limit_r <= 8'd255;
    end else if (reg_wr) begin
      case (paddr[3:2])
        REG_FADE_CEILING:  fade_ceiling_r  <= pwdata[7:0];
        REG_FADE_FLOOR:    fade_floor_r    <= pwdata[7:0];
        REG_CHANNEL_LIMIT: channel_limit_r <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // readback
  always_comb begin
    case (paddr[3:2])
      REG_FADE_CEILING:  prdata = {24'd0, fade_ceiling_r};
      REG_FADE_FLOOR:    prdata = {24'd0, fade_floor_r};
      REG_CHANNEL_LIMIT: prdata = {24'd0, channel_limit_r};
      default:           prdata = 32'd0;
    endcase
  end

  // sequencing of clear pass, fetch/execute loop and result handoff
  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, program state and result register
  lcs_dpath #(
    .PROGRAM_DEPTH     (PROGRAM_DEPTH),
    .CHANNEL_COUNT     (CHANNEL_COUNT),
    .MAX_STEPS_PER_TICK(MAX_STEPS_PER_TICK)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_entry_address (in_entry_address),
    .in_command_code  (in_command_code),
    .in_argument      (in_argument),
    .in_read_channel  (in_read_channel),
    .fade_ceiling     (fade_ceiling_r),
    .fade_floor       (fade_floor_r),
    .channel_limit    (channel_limit_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_out    (out_level_out),
    .out_step_now     (out_step_now),
    .out_step_overflow(out_step_overflow)
  );

endmodule

### sv/lcs_checker.sv
// port-level checker for the light channel sequencer and its bind
module lcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_level_out,
  input logic [7:0]  out_step_now,
  input logic        out_step_overflow,
  input logic        pready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level_out) &&
    $stable(out_step_now) && $stable(out_step_overflow))
    else $error("result changed while stalled");

  // only one request in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another in flight");

  // overflow comes from ticks, levels from reads
  a_ovf_no_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_overflow |-> out_level_out == 8'd0)
    else $error("overflow result carries a level");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind light_channel_sequencer lcs_checker u_lcs_checker (.*);

### dv/light_channel_sequencer_checker.sv
// result checker for the light channel sequencer: tracks registers, predicts and compares
module light_channel_sequencer_checker import lcs_pkg::*; #(
  parameter int PROGRAM_DEPTH      = 256,
  parameter int CHANNEL_COUNT      = 64,
  parameter int MAX_STEPS_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_entry_address,
  input  logic [3:0]  in_command_code,
  input  logic [15:0] in_argument,
  input  logic [5:0]  in_read_channel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_level_out,
  input  logic [7:0]  out_step_now,
  input  logic        out_step_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] step;
    logic       overflow;
  } seq_result_t;

  // shadow copy of the sequencer
  logic [3:0]  prog_cmd [PROGRAM_DEPTH];
  logic [15:0] prog_arg [PROGRAM_DEPTH];
  logic [7:0]  levels [CHANNEL_COUNT];
  int unsigned step_ptr;
  int unsigned sel_ch;
  int unsigned loop_start;
  logic [15:0] wait_cnt;
  logic [15:0] loop_cnt;
  logic [7:0]  ceil_lvl;
  logic [7:0]  floor_lvl;
  logic [7:0]  level_limit;

  seq_result_t due_results [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic void flag(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0d actual %0d at %0t", what, want, got, $realtime);
    end
  endfunction

  function automatic void store_level(int unsigned v);
    levels[sel_ch] = (v > level_limit) ? level_limit : 8'(v);
  endfunction

  function automatic int unsigned next_index(int unsigned s);
    return (s + 1 >= PROGRAM_DEPTH) ? 0 : s + 1;
  endfunction

  // one program entry; returns 1 when the tick stops here
  function automatic bit exec_entry();
    int unsigned sp;
    int unsigned arg;
    int unsigned lvl;
    bit halt;
    sp = step_ptr % PROGRAM_DEPTH;
    arg = prog_arg[sp];
    lvl = levels[sel_ch];
    halt = 1'b0;
    case (prog_cmd[sp])
      CMD_FRAME_START: step_ptr = next_index(sp);
      CMD_FRAME_END: begin
        step_ptr = next_index(sp);
        halt = 1'b1;
      end
      CMD_SELECT: begin
        sel_ch = arg % CHANNEL_COUNT;
        step_ptr = next_index(sp);
      end
      CMD_SET: begin
        store_level(arg & 8'hFF);
        step_ptr = next_index(sp);
      end
      CMD_SET_TIME: begin
        wait_cnt = 16'(arg);
        step_ptr = next_index(sp);
      end
      CMD_WAIT: begin
        if (wait_cnt > 0) begin
          wait_cnt--;
          halt = 1'b1;
        end else begin
          step_ptr = next_index(sp);
        end
      end
      CMD_JUMP: step_ptr = arg % PROGRAM_DEPTH;
      CMD_FADE_UP: begin
        if (lvl < ceil_lvl) begin
          store_level((ceil_lvl - lvl >= arg) ? lvl + arg : ceil_lvl);
        end else begin
          store_level(lvl);
        end
        step_ptr = next_index(sp);
      end
      CMD_FADE_DOWN: begin
        if (lvl > floor_lvl) begin
          store_level((lvl - floor_lvl >= arg) ? lvl - arg : floor_lvl);
        end else begin
          store_level(lvl);
        end
        step_ptr = next_index(sp);
      end
      CMD_LOOP_INIT: begin
        loop_cnt = 16'(arg);
        step_ptr = next_index(sp);
        loop_start = step_ptr;
      end
      CMD_LOOP_CHECK: begin
        if (loop_cnt > 0) begin
          loop_cnt--;
          step_ptr = loop_start % PROGRAM_DEPTH;
        end else begin
          step_ptr = next_index(sp);
        end
      end
      default: begin
        step_ptr = 0;
        halt = 1'b1;
      end
    endcase
    return halt;
  endfunction

  // returns the overflow flag of one tick
  function automatic logic run_tick();
    for (int n = 0; n < MAX_STEPS_PER_TICK; n++) begin
      if (exec_entry()) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic seq_result_t predict_request(logic [1:0] op, logic [7:0] addr,
                                                  logic [3:0] cmd, logic [15:0] arg,
                                                  logic [5:0] rch);
    seq_result_t r;
    r = '0;
    case (op)
      OP_TICK: r.overflow = run_tick();
      OP_WRITE: begin
        if (addr < PROGRAM_DEPTH) begin
          prog_cmd[addr] = cmd;
          prog_arg[addr] = arg;
        end
      end
      OP_READ: begin
        if (rch < CHANNEL_COUNT) r.level = levels[rch];
      end
      default: ;
    endcase
    r.step = 8'(step_ptr);
    return r;
  endfunction

  always @(posedge clk) begin
    seq_result_t want;
    logic [7:0] reg_now;
    if (!rst_n) begin
      for (int i = 0; i < PROGRAM_DEPTH; i++) begin
        prog_cmd[i] = '0;
        prog_arg[i] = '0;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) levels[i] = '0;
      step_ptr = 0;
      sel_ch = 0;
      loop_start = 0;
      wait_cnt = '0;
      loop_cnt = '0;
      ceil_lvl = 8'd255;
      floor_lvl = 8'd0;
      level_limit = 8'd255;
      due_results.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        case (paddr[3:2])
          REG_FADE_CEILING:  reg_now = ceil_lvl;
          REG_FADE_FLOOR:    reg_now = floor_lvl;
          REG_CHANNEL_LIMIT: reg_now = level_limit;
          default:           reg_now = '0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_FADE_CEILING:  ceil_lvl = pwdata[7:0];
            REG_FADE_FLOOR:    floor_lvl = pwdata[7:0];
            REG_CHANNEL_LIMIT: level_limit = pwdata[7:0];
            default: ;
          endcase
        end else if (prdata[7:0] !== reg_now) begin
          flag("register readback", reg_now, prdata[7:0]);
        end
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: result with nothing outstanding, step_now %0d at %0t",
                     out_step_now, $realtime);
          end
        end else begin
          want = due_results.pop_front();
          if (out_level_out !== want.level) flag("level_out", want.level, out_level_out);
          if (out_step_now !== want.step) flag("step_now", want.step, out_step_now);
          if (out_step_overflow !== want.overflow) begin
            flag("step_overflow", want.overflow, out_step_overflow);
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_request(in_opcode, in_entry_address, in_command_code,
                                              in_argument, in_read_channel));
      end
    end
    pending <= due_results.size();
  end

endmodule

### dv/light_channel_sequencer_test.sv
// testbench top for the light channel sequencer: clock, reset, stimulus and verdict
module light_channel_sequencer_test import lcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no function, unknown command range
  localparam logic [1:0] OP_NONE           = 2'd3;
  localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd11;
  localparam logic [3:0] CMD_LAST_UNKNOWN  = 4'd15;

  // cycles without any request or result moving before the run is called hung
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_entry_address = '0;
  logic [3:0]  in_command_code = '0;
  logic [15:0] in_argument = '0;
  logic [5:0]  in_read_channel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_level_out;
  logic [7:0]  out_step_now;
  logic        out_step_overflow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;

  // idle and stall odds in percent, changed per phase
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  light_channel_sequencer dut (.*);

  light_channel_sequencer_checker checker_i (.*);

  always #4 clk = ~clk;

  // receiver side: random stall decided at each falling edge
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog: anything moving on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("light_channel_sequencer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request; entered and left at a falling edge, valid stays high between
  // back-to-back requests
  task automatic send_request(input logic [1:0] op, input logic [7:0] addr,
                              input logic [3:0] cmd, input logic [15:0] arg,
                              input logic [5:0] rch);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_address <= addr;
    in_command_code <= cmd;
    in_argument <= arg;
    in_read_channel <= rch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_entry(input logic [7:0] addr, input logic [3:0] cmd,
                             input logic [15:0] arg);
    send_request(OP_WRITE, addr, cmd, arg, 6'($urandom));
  endtask

  // fields a tick ignores carry random bits
  task automatic tick();
    send_request(OP_TICK, 8'($urandom), 4'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic read_level(input logic [5:0] ch);
    send_request(OP_READ, 8'($urandom), 4'($urandom), 16'($urandom), ch);
  endtask

  // setup and access cycle, then psel drops and the task idles so psel never gets two updates
  // in one step
  task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // write all three registers, then read each back
  task automatic set_fades(input logic [7:0] ceil_v, input logic [7:0] floor_v,
                           input logic [7:0] limit_v);
    reg_access(REG_FADE_CEILING, 1'b1, ceil_v);
    reg_access(REG_FADE_FLOOR, 1'b1, floor_v);
    reg_access(REG_CHANNEL_LIMIT, 1'b1, limit_v);
    reg_access(REG_FADE_CEILING, 1'b0, '0);
    reg_access(REG_FADE_FLOOR, 1'b0, '0);
    reg_access(REG_CHANNEL_LIMIT, 1'b0, '0);
  endtask

  // wait out every outstanding result, plus a margin so the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // random program entry: mostly well-formed commands, short waits and loops so
  // programs keep moving, a few unknown codes
  function automatic void random_entry(output logic [3:0] cmd, output logic [15:0] arg);
    if ($urandom_range(99) < 6) begin
      cmd = 4'($urandom_range(CMD_LAST_UNKNOWN, CMD_FIRST_UNKNOWN));
      arg = 16'($urandom);
    end else begin
      cmd = 4'($urandom_range(CMD_LOOP_CHECK, CMD_FRAME_START));
      case (cmd)
        CMD_SET_TIME:  arg = 16'($urandom_range(3));
        CMD_LOOP_INIT: arg = 16'($urandom_range(4));
        CMD_FADE_UP, CMD_FADE_DOWN: begin
          arg = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(300));
        end
        default:       arg = 16'($urandom);
      endcase
    end
  endfunction

  task automatic random_request();
    int unsigned roll;
    logic [3:0] cmd;
    logic [15:0] arg;
    roll = $urandom_range(99);
    if (roll < 45) begin
      tick();
    end else if (roll < 75) begin
      random_entry(cmd, arg);
      write_entry(8'($urandom), cmd, arg);
    end else if (roll < 95) begin
      read_level(6'($urandom));
    end else begin
      send_request(OP_NONE, 8'($urandom), 4'($urandom), 16'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    logic [3:0] cmd;
    logic [15:0] arg;
    // reset held at the start, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part: limit below the ceiling so clamping shows on set and fade
    set_fades(8'd250, 8'd10, 8'd200);
    read_level(6'd0);
    read_level(6'd63);
    send_request(OP_NONE, 8'hFF, 4'hF, 16'hFFFF, 6'h3F);
    // select beyond channel count, set with high byte, fade to both bounds,
    // a loop of three passes, a wait with time left, jump beyond the store
    write_entry(8'd0, CMD_SELECT, 16'hFFC5);
    write_entry(8'd1, CMD_SET, 16'h01FF);
    write_entry(8'd2, CMD_FADE_DOWN, 16'hFFFF);
    write_entry(8'd3, CMD_FADE_UP, 16'h0010);
    write_entry(8'd4, CMD_LOOP_INIT, 16'd2);
    write_entry(8'd5, CMD_FADE_UP, 16'hFFFF);
    write_entry(8'd6, CMD_LOOP_CHECK, 16'd0);
    write_entry(8'd7, CMD_SET_TIME, 16'd1);
    write_entry(8'd8, CMD_WAIT, 16'd0);
    write_entry(8'd9, CMD_FRAME_START, 16'd0);
    write_entry(8'd10, CMD_JUMP, 16'h010C);
    write_entry(8'd12, CMD_FRAME_END, 16'hFFFF);
    write_entry(8'd13, CMD_FIRST_UNKNOWN, 16'h5A5A);
    // stops at the wait, then at the frame end, then the unknown code restarts
    tick();
    tick();
    tick();
    // a jump onto itself runs into the step limit
    write_entry(8'd14, CMD_JUMP, 16'hFF0E);
    write_entry(8'd0, CMD_JUMP, 16'h000E);
    tick();
    read_level(6'd5);
    write_entry(8'd255, CMD_FRAME_END, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // idle mix cycles through none, sender, receiver, both
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 54;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      // register settings: reset-like, all extremes flipped, mid values,
      // ceiling under floor, then random
      case (p)
        0:       set_fades(8'd255, 8'd0, 8'd255);
        1:       set_fades(8'd0, 8'd255, 8'd0);
        2:       set_fades(8'd180, 8'd40, 8'd120);
        3:       set_fades(8'd30, 8'd200, 8'd255);
        default: set_fades(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // fill the whole store once so any tick after this runs written entries
      if (p == 0) begin
        for (int a = 0; a < 256; a++) begin
          random_entry(cmd, arg);
          write_entry(8'(a), cmd, arg);
        end
      end
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    repeat (32) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("light_channel_sequencer verification clean");
    end else begin
      $display("light_channel_sequencer verification failed");
    end
    $finish;
  end

endmodule
